### hw/rtl/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Pixel types, sector codes and the fixed-point constants shared by the
// converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    localparam int unsigned HUE_W = 9;
    localparam int unsigned CH_W  = 8;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  saturation;
        logic [CH_W-1:0]  brightness;
    } hsv_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } sector_t;

    localparam int unsigned FULL_CIRCLE = 360;
    localparam int unsigned SECTOR_DEG  = 60;
    localparam int unsigned SAT_ONE     = 255;
    localparam int unsigned DENOM       = SAT_ONE * SECTOR_DEG;

    localparam int unsigned REM_W   = 6;
    localparam int unsigned SPROD_W = 14;
    localparam int unsigned PNUM_W  = 16;
    localparam int unsigned QNUM_W  = 22;

    localparam logic [HUE_W-1:0] HUE_WRAP = HUE_W'(FULL_CIRCLE);
    localparam logic [HUE_W-1:0] HUE_S1   = HUE_W'(SECTOR_DEG * 1);
    localparam logic [HUE_W-1:0] HUE_S2   = HUE_W'(SECTOR_DEG * 2);
    localparam logic [HUE_W-1:0] HUE_S3   = HUE_W'(SECTOR_DEG * 3);
    localparam logic [HUE_W-1:0] HUE_S4   = HUE_W'(SECTOR_DEG * 4);
    localparam logic [HUE_W-1:0] HUE_S5   = HUE_W'(SECTOR_DEG * 5);

    localparam logic [REM_W-1:0]   REM_FULL   = REM_W'(SECTOR_DEG);
    localparam logic [CH_W-1:0]    SAT_FULL   = CH_W'(SAT_ONE);
    localparam logic [SPROD_W-1:0] DENOM_FULL = SPROD_W'(DENOM);

    // Division by a constant is a multiplication by a rounded-up reciprocal.
    // The shifts are chosen so that the result is exact over the whole
    // numerator range.
    localparam int unsigned PDIV_SHIFT = 24;
    localparam int unsigned PDIV_W     = 17;
    localparam longint unsigned PDIV_VAL =
        ((64'd1 << PDIV_SHIFT) + SAT_ONE - 1) / SAT_ONE;
    localparam logic [PDIV_W-1:0] PDIV_MUL = PDIV_W'(PDIV_VAL);

    localparam int unsigned QDIV_SHIFT = 36;
    localparam int unsigned QDIV_W     = 23;
    localparam longint unsigned QDIV_VAL =
        ((64'd1 << QDIV_SHIFT) + DENOM - 1) / DENOM;
    localparam logic [QDIV_W-1:0] QDIV_MUL = QDIV_W'(QDIV_VAL);

endpackage

### hw/rtl/hsv_to_rgb_converter_unit.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Five-stage pipeline that turns one HSV pixel into one RGB pixel per clock.
// ----------------------------------------------------------------------------
// A pixel is taken on every clock edge at which start is high; busy is always
// low because the pipeline never stalls. Each pixel produces exactly one
// result on rgb, marked by a one-cycle done strobe, and pixels leave in the
// order they entered. The five register stages are sector split, saturation
// products, numerators, reciprocal multiplies and the sector select. The
// receiver must take every result in the cycle it is shown.
module hsv_to_rgb_converter_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  hsv2rgb_pkg::hsv_t  hsv,
    output logic               done,
    output hsv2rgb_pkg::rgb_t  rgb
);

    logic [3:0] vld_reg;
    logic [3:0] vld_next;
    logic       done_reg;

    hsv2rgb_pkg::sector_t                     sec1_next, sec1_reg;
    logic [hsv2rgb_pkg::REM_W-1:0]            rem1_next, rem1_reg;
    logic [hsv2rgb_pkg::CH_W-1:0]             sat1_reg, val1_reg;
    logic [hsv2rgb_pkg::HUE_W-1:0]            hue_w;
    logic [hsv2rgb_pkg::HUE_W-1:0]            base;

    hsv2rgb_pkg::sector_t                     sec2_reg;
    logic [hsv2rgb_pkg::SPROD_W-1:0]          srem2_next, srem2_reg;
    logic [hsv2rgb_pkg::SPROD_W-1:0]          scmp2_next, scmp2_reg;
    logic [hsv2rgb_pkg::PNUM_W-1:0]           pnum2_next, pnum2_reg;
    logic [hsv2rgb_pkg::CH_W-1:0]             val2_reg;

    hsv2rgb_pkg::sector_t                     sec3_reg;
    logic [hsv2rgb_pkg::QNUM_W-1:0]           qnum3_next, qnum3_reg;
    logic [hsv2rgb_pkg::QNUM_W-1:0]           tnum3_next, tnum3_reg;
    logic [hsv2rgb_pkg::PNUM_W-1:0]           pnum3_reg;
    logic [hsv2rgb_pkg::CH_W-1:0]             val3_reg;

    localparam int unsigned PPROD_W = hsv2rgb_pkg::PNUM_W + hsv2rgb_pkg::PDIV_W;
    localparam int unsigned QPROD_W = hsv2rgb_pkg::QNUM_W + hsv2rgb_pkg::QDIV_W;

    logic [PPROD_W-1:0]                       pprod;
    logic [QPROD_W-1:0]                       qprod;
    logic [QPROD_W-1:0]                       tprod;
    hsv2rgb_pkg::sector_t                     sec4_reg;
    logic [hsv2rgb_pkg::CH_W-1:0]             p4_next, p4_reg;
    logic [hsv2rgb_pkg::CH_W-1:0]             q4_next, q4_reg;
    logic [hsv2rgb_pkg::CH_W-1:0]             t4_next, t4_reg;
    logic [hsv2rgb_pkg::CH_W-1:0]             val4_reg;

    hsv2rgb_pkg::rgb_t                        rgb_next, rgb_reg;

    assign busy = 1'b0;
    assign done = done_reg;
    assign rgb  = rgb_reg;

    assign vld_next = {vld_reg[2:0], start};

    // Stage 1: map a hue of 360 or more to zero and split it into sector and remainder.
    always_comb
    begin
        hue_w = (hsv.hue >= hsv2rgb_pkg::HUE_WRAP) ? '0 : hsv.hue;
        priority if (hue_w >= hsv2rgb_pkg::HUE_S5)
        begin
            sec1_next = hsv2rgb_pkg::SEC_MAG_RED;
            base      = hsv2rgb_pkg::HUE_S5;
        end
        else if (hue_w >= hsv2rgb_pkg::HUE_S4)
        begin
            sec1_next = hsv2rgb_pkg::SEC_BLU_MAG;
            base      = hsv2rgb_pkg::HUE_S4;
        end
        else if (hue_w >= hsv2rgb_pkg::HUE_S3)
        begin
            sec1_next = hsv2rgb_pkg::SEC_CYN_BLU;
            base      = hsv2rgb_pkg::HUE_S3;
        end
        else if (hue_w >= hsv2rgb_pkg::HUE_S2)
        begin
            sec1_next = hsv2rgb_pkg::SEC_GRN_CYN;
            base      = hsv2rgb_pkg::HUE_S2;
        end
        else if (hue_w >= hsv2rgb_pkg::HUE_S1)
        begin
            sec1_next = hsv2rgb_pkg::SEC_YEL_GRN;
            base      = hsv2rgb_pkg::HUE_S1;
        end
        else
        begin
            sec1_next = hsv2rgb_pkg::SEC_RED_YEL;
            base      = '0;
        end
        rem1_next = hsv2rgb_pkg::REM_W'(hue_w - base);
    end

    // Stage 2: saturation products.
    always_comb
    begin
        srem2_next = hsv2rgb_pkg::SPROD_W'(sat1_reg * rem1_reg);
        scmp2_next = hsv2rgb_pkg::SPROD_W'(sat1_reg * (hsv2rgb_pkg::REM_FULL - rem1_reg));
        pnum2_next = hsv2rgb_pkg::PNUM_W'(val1_reg * (hsv2rgb_pkg::SAT_FULL - sat1_reg));
    end

    // Stage 3: numerators of q and t over the common denominator.
    always_comb
    begin
        qnum3_next = hsv2rgb_pkg::QNUM_W'(val2_reg * (hsv2rgb_pkg::DENOM_FULL - srem2_reg));
        tnum3_next = hsv2rgb_pkg::QNUM_W'(val2_reg * (hsv2rgb_pkg::DENOM_FULL - scmp2_reg));
    end

    // Stage 4: truncating division by reciprocal multiplication.
    always_comb
    begin
        pprod   = PPROD_W'(pnum3_reg) * PPROD_W'(hsv2rgb_pkg::PDIV_MUL);
        qprod   = QPROD_W'(qnum3_reg) * QPROD_W'(hsv2rgb_pkg::QDIV_MUL);
        tprod   = QPROD_W'(tnum3_reg) * QPROD_W'(hsv2rgb_pkg::QDIV_MUL);
        p4_next = pprod[hsv2rgb_pkg::PDIV_SHIFT +: hsv2rgb_pkg::CH_W];
        q4_next = qprod[hsv2rgb_pkg::QDIV_SHIFT +: hsv2rgb_pkg::CH_W];
        t4_next = tprod[hsv2rgb_pkg::QDIV_SHIFT +: hsv2rgb_pkg::CH_W];
    end

    // Stage 5: place the terms by sector.
    always_comb
    begin
        unique case (sec4_reg)
            hsv2rgb_pkg::SEC_RED_YEL: rgb_next = '{red: val4_reg, green: t4_reg,   blue: p4_reg};
            hsv2rgb_pkg::SEC_YEL_GRN: rgb_next = '{red: q4_reg,   green: val4_reg, blue: p4_reg};
            hsv2rgb_pkg::SEC_GRN_CYN: rgb_next = '{red: p4_reg,   green: val4_reg, blue: t4_reg};
            hsv2rgb_pkg::SEC_CYN_BLU: rgb_next = '{red: p4_reg,   green: q4_reg,   blue: val4_reg};
            hsv2rgb_pkg::SEC_BLU_MAG: rgb_next = '{red: t4_reg,   green: p4_reg,   blue: val4_reg};
            default:                  rgb_next = '{red: val4_reg, green: p4_reg,   blue: q4_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= vld_next;
            done_reg <= vld_reg[3];
        end
    end

    always_ff @(posedge clk)
    begin
        sec1_reg  <= sec1_next;
        rem1_reg  <= rem1_next;
        sat1_reg  <= hsv.saturation;
        val1_reg  <= hsv.brightness;

        sec2_reg  <= sec1_reg;
        srem2_reg <= srem2_next;
        scmp2_reg <= scmp2_next;
        pnum2_reg <= pnum2_next;
        val2_reg  <= val1_reg;

        sec3_reg  <= sec2_reg;
        qnum3_reg <= qnum3_next;
        tnum3_reg <= tnum3_next;
        pnum3_reg <= pnum2_reg;
        val3_reg  <= val2_reg;

        sec4_reg  <= sec3_reg;
        p4_reg    <= p4_next;
        q4_reg    <= q4_next;
        t4_reg    <= t4_next;
        val4_reg  <= val3_reg;

        rgb_reg   <= rgb_next;
    end

endmodule
